// ===== design/mvu_pkg.sv =====
package mvu_pkg;

  localparam int unsigned KindW           = 2;
  localparam int unsigned ResultW         = 48;
  localparam int unsigned CfgW            = 11;
  localparam int unsigned DefValueWidth   = 16;
  localparam int unsigned DefMaxDotLength = 1024;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [KindW-1:0] {
    KindDot = 2'd0,
    KindAdd = 2'd1,
    KindMul = 2'd2
  } kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/mvu_fifo.sv =====
module mvu_fifo #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [Width-1:0]    rdata_o,
  output mvu_pkg::q_status_t  status_o
);
  import mvu_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue holds more entries than its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

endmodule

// ===== design/mvu_front.sv =====
module mvu_front #(
  parameter int unsigned VALUE_WIDTH    = mvu_pkg::DefValueWidth,
  parameter int unsigned MAX_DOT_LENGTH = mvu_pkg::DefMaxDotLength
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  input  logic [2*VALUE_WIDTH-1:0]                      operands_i,
  input  logic [mvu_pkg::KindW-1:0]                     kind_i,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [mvu_pkg::CfgW-1:0]                      cfg_data_i,
  input  mvu_pkg::q_status_t                            q_status_i,
  output logic                                          push_o,
  output logic [mvu_pkg::KindW+2*VALUE_WIDTH-1:0]       entry_o,
  output logic [$clog2(MAX_DOT_LENGTH+1)-1:0]           eff_len_o
);
  import mvu_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_DOT_LENGTH + 1);
  localparam int unsigned CmpW = (LenW > CfgW) ? LenW : CfgW;

  logic            known_kind;
  logic [LenW-1:0] eff_len_q, eff_len_d;

  // kind 3 is taken and dropped here, it never reaches the queue
  always_comb begin
    case (kind_e'(kind_i))
      KindDot, KindAdd, KindMul: known_kind = 1'b1;
      default:                   known_kind = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !q_status_i.full;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o && known_kind;
  assign entry_o         = {operands_i, kind_i};

  // zero acts as one, anything above the maximum is clamped
  always_comb begin
    if (cfg_data_i == '0) begin
      eff_len_d = LenW'(1);
    end else if (CmpW'(cfg_data_i) > CmpW'(MAX_DOT_LENGTH)) begin
      eff_len_d = LenW'(MAX_DOT_LENGTH);
    end else begin
      eff_len_d = LenW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= LenW'(1);
    end else if (cfg_valid_i) begin
      eff_len_q <= eff_len_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign eff_len_o   = eff_len_q;

endmodule

// ===== design/mvu_back.sv =====
module mvu_back #(
  parameter int unsigned VALUE_WIDTH    = mvu_pkg::DefValueWidth,
  parameter int unsigned MAX_DOT_LENGTH = mvu_pkg::DefMaxDotLength
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  mvu_pkg::q_status_t                            q_status_i,
  input  logic [mvu_pkg::KindW+2*VALUE_WIDTH-1:0]       q_data_i,
  output logic                                          pop_o,
  input  logic [$clog2(MAX_DOT_LENGTH+1)-1:0]           eff_len_i,
  output logic                                          m_valid_o,
  input  logic                                          m_ready_i,
  output logic [mvu_pkg::ResultW-1:0]                   m_value_o,
  output logic [mvu_pkg::KindW-1:0]                     m_kind_o
);
  import mvu_pkg::*;

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned FracW = VALUE_WIDTH / 2;
  localparam int unsigned LenW  = $clog2(MAX_DOT_LENGTH + 1);
  localparam int unsigned CntW  = (MAX_DOT_LENGTH > 1) ? $clog2(MAX_DOT_LENGTH) : 1;
  localparam int unsigned CmpW  = LenW + 1;

  // queue head
  kind_e                q_kind;
  logic signed [VW-1:0] q_left, q_right;
  logic                 q_valid;

  // operation stage
  logic signed [2*VW-1:0] prod;
  logic signed [VW:0]     sum_lr;
  logic signed [63:0]     prod_ext, sum_ext;
  logic [ResultW-1:0]     a_value_d, a_value_q;
  kind_e                  a_kind_q;
  logic                   a_valid_q;
  logic                   a_ready, a_drain;

  // accumulate and output stage
  logic [ResultW-1:0] acc_q, acc_d, acc_sum;
  logic [CntW-1:0]    term_q, term_d;
  logic               is_dot, last_term, emit_req, can_load;
  logic               out_valid_q, out_valid_d;
  logic [ResultW-1:0] out_value_q;
  kind_e              out_kind_q;

  assign q_kind  = kind_e'(q_data_i[KindW-1:0]);
  assign q_left  = q_data_i[KindW+VW-1:KindW];
  assign q_right = q_data_i[KindW+2*VW-1:KindW+VW];
  assign q_valid = !q_status_i.empty;

  assign prod     = q_left * q_right;
  assign prod_ext = 64'(prod);
  assign sum_lr   = (VALUE_WIDTH+1)'(q_left) + (VALUE_WIDTH+1)'(q_right);
  assign sum_ext  = 64'(sum_lr) <<< FracW;

  always_comb begin
    case (q_kind)
      KindAdd: a_value_d = sum_ext[ResultW-1:0];
      default: a_value_d = prod_ext[ResultW-1:0];
    endcase
  end

  assign is_dot    = (a_kind_q == KindDot);
  assign acc_sum   = acc_q + a_value_q;
  assign last_term = (CmpW'(term_q) + CmpW'(1)) >= CmpW'(eff_len_i);
  assign emit_req  = !is_dot || last_term;
  assign can_load  = !out_valid_q || m_ready_i;
  // a dot term that completes no sum drains without needing the output slot
  assign a_drain   = a_valid_q && (!emit_req || can_load);
  assign a_ready   = !a_valid_q || a_drain;
  assign pop_o     = q_valid && a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_value_q <= a_value_d;
      a_kind_q  <= q_kind;
    end
  end

  always_comb begin
    acc_d  = acc_q;
    term_d = term_q;
    if (a_drain && is_dot) begin
      if (last_term) begin
        acc_d  = '0;
        term_d = '0;
      end else begin
        acc_d  = acc_sum;
        term_d = term_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (a_drain && emit_req) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      term_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_drain && emit_req) begin
      out_value_q <= is_dot ? acc_sum : a_value_q;
      out_kind_q  <= a_kind_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_kind_o  = out_kind_q;

  a_clear_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_drain && is_dot && last_term) |=> (acc_q == '0) && (term_q == '0))
    else $error("accumulator not cleared after a completed sum");

  a_elementwise_keeps_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_drain && !is_dot) |=> $stable(acc_q) && $stable(term_q))
    else $error("elementwise request disturbed the accumulator");

endmodule

// ===== design/streaming_mac_vector_unit_core.sv =====
// path: a result reaches m_axis through the queue, the operation register and the
// output register; dot terms that do not complete a sum give no result
// throughput: one request per cycle while m_axis_tready is high and the queue has room
// reset: asynchronous active low; clears the accumulator and term count, dot length to 1
module streaming_mac_vector_unit_core #(
  parameter int unsigned VALUE_WIDTH    = mvu_pkg::DefValueWidth,
  parameter int unsigned MAX_DOT_LENGTH = mvu_pkg::DefMaxDotLength
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // left_operand, right_operand, zero padding
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // kind
  input  logic [mvu_pkg::KindW-1:0]               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // result_value
  output logic [mvu_pkg::ResultW-1:0]             m_axis_tdata,
  // result_kind
  output logic [mvu_pkg::KindW-1:0]               m_axis_tuser,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [mvu_pkg::CfgW-1:0]                cfg_data_i
);
  import mvu_pkg::*;

  localparam int unsigned EntryW = KindW + 2 * VALUE_WIDTH;
  localparam int unsigned LenW   = $clog2(MAX_DOT_LENGTH + 1);

  q_status_t         q_status;
  logic              push, pop;
  logic [EntryW-1:0] entry, q_data;
  logic [LenW-1:0]   eff_len;

  mvu_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_DOT_LENGTH(MAX_DOT_LENGTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .operands_i     (s_axis_tdata[2*VALUE_WIDTH-1:0]),
    .kind_i         (s_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .entry_o        (entry),
    .eff_len_o      (eff_len)
  );

  mvu_fifo #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .pop_i   (pop),
    .rdata_o (q_data),
    .status_o(q_status)
  );

  mvu_back #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .MAX_DOT_LENGTH(MAX_DOT_LENGTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_status_i(q_status),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .eff_len_i (eff_len),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_value_o (m_axis_tdata),
    .m_kind_o  (m_axis_tuser)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mvu_pkg::*;

  localparam logic [KindW-1:0] KindUnused  = 2'd3;
  localparam int unsigned      MaxDotLen   = DefMaxDotLength;
  localparam int unsigned      StallLimit  = 2000;
  localparam int unsigned      SettleWait  = 4;

  typedef struct {
    logic [ResultW-1:0] value;
    logic [KindW-1:0]   kind;
  } mac_result_t;

  class mac_scoreboard;
    logic [CfgW-1:0]    dot_len;
    logic [ResultW-1:0] acc;
    int unsigned        terms;
    int unsigned        errors;
    mac_result_t        pending[$];

    function new();
      dot_len = 1;
      acc     = '0;
      terms   = 0;
      errors  = 0;
    endfunction

    function void set_length(logic [CfgW-1:0] len);
      dot_len = len;
    endfunction

    // predicted result of one accepted request, if any
    function void note_request(logic [KindW-1:0] kind, logic signed [15:0] lhs,
                               logic signed [15:0] rhs);
      logic signed [ResultW-1:0] prod;
      logic signed [ResultW-1:0] sum;
      logic [ResultW-1:0]        acc_next;
      int unsigned               eff_len;
      mac_result_t               res;
      prod = lhs * rhs;
      sum  = lhs + rhs;
      eff_len = (dot_len == 0) ? 1 : ((dot_len > MaxDotLen) ? MaxDotLen : dot_len);
      if (kind == KindDot) begin
        acc_next = acc + prod;
        if (terms + 1 >= eff_len) begin
          res.value = acc_next;
          res.kind  = KindDot;
          pending.push_back(res);
          acc   = '0;
          terms = 0;
        end else begin
          acc   = acc_next;
          terms = terms + 1;
        end
      end else if (kind == KindAdd) begin
        res.value = sum << 8;
        res.kind  = KindAdd;
        pending.push_back(res);
      end else if (kind == KindMul) begin
        res.value = prod;
        res.kind  = KindMul;
        pending.push_back(res);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [ResultW-1:0] value, logic [KindW-1:0] kind);
      mac_result_t exp_res;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h kind %0d", value, kind));
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value)
        report_mismatch($sformatf("value %h, predicted %h", value, exp_res.value));
      if (kind !== exp_res.kind)
        report_mismatch($sformatf("kind %0d, predicted %0d", kind, exp_res.kind));
    endtask

    task check_drained();
      if (pending.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // left_operand, right_operand
  logic [KindW-1:0]     s_axis_tuser = '0;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ResultW-1:0]   m_axis_tdata;        // result_value
  logic [KindW-1:0]     m_axis_tuser;        // result_kind
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i = '0;

  int unsigned   tx_idle_pct = 38;
  int unsigned   rx_idle_pct = 49;
  int unsigned   quiet_cycles = 0;
  mac_scoreboard sb = new();

  streaming_mac_vector_unit_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      if (cfg_valid_i && cfg_ready_o)
        sb.set_length(cfg_data_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [KindW-1:0] kind, input logic [15:0] lhs,
                           input logic [15:0] rhs);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {rhs, lhs};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    int unsigned      pick;
    logic [KindW-1:0] kind;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55)      kind = KindDot;
      else if (pick < 75) kind = KindAdd;
      else if (pick < 95) kind = KindMul;
      else                kind = KindUnused;
      send_item(kind, pick_operand(), pick_operand());
    end
  endtask

  // drop valid and let every predicted result come out, plus pipeline slack
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CfgW-1:0] len);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // operand extremes on every operation, unused kind, dot length 1 after reset
    send_item(KindAdd, 16'h8000, 16'h8000);
    send_item(KindAdd, 16'h7fff, 16'h7fff);
    send_item(KindAdd, 16'h8000, 16'h7fff);
    send_item(KindAdd, 16'hffff, 16'h0001);
    send_item(KindMul, 16'h8000, 16'h8000);
    send_item(KindMul, 16'h7fff, 16'h7fff);
    send_item(KindMul, 16'h8000, 16'h7fff);
    send_item(KindMul, 16'hffff, 16'hffff);
    send_item(KindMul, 16'h0100, 16'h0100);
    send_item(KindDot, 16'h8000, 16'h8000);
    send_item(KindDot, 16'h7fff, 16'h8000);
    send_item(KindDot, 16'h0000, 16'h0000);
    send_item(KindUnused, 16'h7fff, 16'h7fff);
    send_item(KindUnused, 16'h8000, 16'h0000);
    send_item(KindDot, 16'hffff, 16'h0001);

    // zero length behaves as one
    wait_idle();
    write_length('0);
    send_random(40);

    wait_idle();
    write_length(11'd3);
    send_random(100);

    tx_idle_pct = 49;
    rx_idle_pct = 38;

    // a long sum with the largest products, a few elementwise requests mixed in
    wait_idle();
    write_length(11'd256);
    for (int i = 0; i < 256; i++) begin
      send_item(KindDot, 16'h8000, 16'h8000);
      if (i % 128 == 100) send_item(KindMul, pick_operand(), pick_operand());
    end

    // oversized length clamps, then shrink it with a partial sum pending
    wait_idle();
    write_length('1);
    repeat (40) send_item(KindDot, pick_operand(), pick_operand());
    wait_idle();
    write_length(11'd5);
    send_random(60);

    wait_idle();
    write_length(11'($urandom_range(2, 12)));
    send_random(50);
    wait_idle();
    send_random(50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;

    wait_idle();
    write_length(11'd1);
    send_random(80);

    wait_idle();
    write_length(11'd7);
    send_random(60);

    wait_idle();
    sb.check_drained();
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
